// File: hdl/assert_macros.svh
// Assertion macros shared by the feedback change detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that expr holds at every clock edge outside reset.
`define FBCD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that cons holds in the same cycle whenever ante holds.
`define FBCD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FBCD_ASSERT_ALWAYS(lbl, expr, msg)
`define FBCD_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/fbcd_pkg.sv
// Package of constants and types for the feedback bit change detector.
package fbcd_pkg;

    // Default number of modules the store is sized for
    localparam int MAX_MODULES_DEF = 32;

    // Poll command base value
    localparam int CMD_BASE = 128;

    // Input item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Result kinds
    localparam logic RES_CMD   = 1'b0;
    localparam logic RES_EVENT = 1'b1;

    // Register index decode (word index taken from paddr[2])
    localparam logic REG_MODULE_COUNT = 1'b0;

    // Width of the module count register
    localparam int COUNT_W = 6;

    // One result beat
    typedef struct packed {
        logic       result_kind;
        logic [7:0] command_byte;
        logic [8:0] pin_address;
        logic       occupied;
        logic       last;
    } result_t;

endpackage

// File: hdl/fbcd_store.sv
// Module byte store: synchronous RAM with per-entry valid bits and write forwarding.
module fbcd_store #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    output logic [7:0]               rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       q_reg;
    logic             q_vld_reg;
    logic             fwd_reg;
    logic [7:0]       fwd_data_reg;

    // RAM array: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Valid bits stand in for the all-zero reset of the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            q_vld_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                q_vld_reg <= valid_reg[rd_addr];
                fwd_reg   <= wr_en && (wr_addr == rd_addr);
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Same-cycle write wins over the stale RAM word
    assign rd_data = fwd_reg ? fwd_data_reg : (q_vld_reg ? q_reg : 8'h00);

endmodule

// File: hdl/feedback_bit_change_detector.sv
// Top level of the feedback bit change detector: poll control, byte store and event emitter.
//
// A start-poll beat answers with one command result; each data beat of a poll reads the stored
// byte of the current module from a registered-read RAM, and the changed bits come out as pin
// change events, most significant first, one per cycle from a single emitter while the output
// is not stalled. An item is accepted every cycle while the emitter keeps up; a data byte with
// n changed bits gives n events. The store is cleared at reset through per-entry valid bits,
// with no clearing pass. The module_count register sits at byte address 0 of the APB port.
`include "assert_macros.svh"

module feedback_bit_change_detector #(
    parameter int MAX_MODULES = fbcd_pkg::MAX_MODULES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  command_byte,
    output logic [8:0]  pin_address,
    output logic        occupied,
    output logic        last
);

    localparam int STORE_DEPTH = (MAX_MODULES + 1) / 2 * 2;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(STORE_DEPTH + 1);
    localparam int RW          = ((POS_W > fbcd_pkg::COUNT_W) ? POS_W : fbcd_pkg::COUNT_W) + 1;
    localparam int AW          = (IDX_W + 4 > 9) ? IDX_W + 4 : 9;

    // control state
    logic [fbcd_pkg::COUNT_W-1:0] module_count_reg;
    logic [POS_W-1:0]             pos_reg;
    logic                         poll_active_reg;

    // stage 1: item waiting for its store word
    logic             s1_valid_reg;
    logic             s1_is_cmd_reg;
    logic [7:0]       s1_cmd_reg;
    logic [7:0]       s1_byte_reg;
    logic [IDX_W-1:0] s1_mod_reg;

    // emitter
    logic             em_valid_reg;
    logic             em_is_cmd_reg;
    logic [7:0]       em_cmd_reg;
    logic [7:0]       em_mask_reg;
    logic [7:0]       em_byte_reg;
    logic [IDX_W-1:0] em_mod_reg;

    // output register
    logic              out_valid_reg;
    fbcd_pkg::result_t out_reg;

    logic                  cfg_wr;
    logic [RW-1:0]         active;
    logic [RW-1:0]         pairs;
    logic [RW-1:0]         reads;
    logic [7:0]            cmd_value;
    logic                  pos_in_range;
    logic [POS_W-1:0]      pos_inc;
    logic                  in_acc;
    logic                  s1_load;
    logic                  s1_move;
    logic [7:0]            rd_data;
    logic [7:0]            diff;
    logic                  out_take;
    logic                  emit;
    logic                  em_free;
    logic [2:0]            sel;
    logic [7:0]            rest_mask;
    logic                  em_last;
    logic [3:0]            pin;
    logic [AW-1:0]         addr_w;
    fbcd_pkg::result_t     res_next;

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == fbcd_pkg::REG_MODULE_COUNT);
    assign prdata = (paddr[2] == fbcd_pkg::REG_MODULE_COUNT) ? 32'(module_count_reg) : 32'h0;

    // Poll length from the clamped count
    always_comb
    begin
        active = (RW'(module_count_reg) > RW'(MAX_MODULES)) ? RW'(MAX_MODULES)
                                                            : RW'(module_count_reg);
        pairs     = (active + RW'(1)) >> 1;
        reads     = pairs << 1;
        cmd_value = 8'(fbcd_pkg::CMD_BASE + int'(pairs));
        pos_in_range = RW'(pos_reg) < reads;
        pos_inc   = pos_reg + POS_W'(1);
    end

    // Handshake and stage movement
    assign out_take = !out_valid_reg || !out_stall;
    assign emit     = em_valid_reg && out_take;
    assign em_free  = !em_valid_reg || (emit && em_last);
    assign s1_move  = s1_valid_reg && em_free;
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_acc   = in_valid && !in_stall;
    assign s1_load  = in_acc && ((kind == fbcd_pkg::KIND_START) ||
                                 ((kind == fbcd_pkg::KIND_DATA) && poll_active_reg &&
                                  pos_in_range));

    // Byte store
    fbcd_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s1_load && (kind == fbcd_pkg::KIND_DATA)),
        .rd_addr (pos_reg[IDX_W-1:0]),
        .wr_en   (s1_move && !s1_is_cmd_reg),
        .wr_addr (s1_mod_reg),
        .wr_data (s1_byte_reg),
        .rd_data (rd_data)
    );

    assign diff = s1_byte_reg ^ rd_data;

    // Highest pending changed bit
    always_comb
    begin
        sel = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (em_mask_reg[i])
            begin
                sel = 3'(i);
            end
        end
        rest_mask = em_mask_reg & ~(8'h01 << sel);
        em_last   = em_is_cmd_reg || (rest_mask == 8'h00);
        pin       = 4'd8 - {1'b0, sel};
        addr_w    = AW'({em_mod_reg, 3'b000}) + AW'(pin);
    end

    // Next result beat
    always_comb
    begin
        res_next = '0;
        if (em_is_cmd_reg)
        begin
            res_next.result_kind  = fbcd_pkg::RES_CMD;
            res_next.command_byte = em_cmd_reg;
            res_next.last         = 1'b1;
        end
        else
        begin
            res_next.result_kind = fbcd_pkg::RES_EVENT;
            res_next.pin_address = addr_w[8:0];
            res_next.occupied    = em_byte_reg[sel];
            res_next.last        = em_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_count_reg <= fbcd_pkg::COUNT_W'(1);
            pos_reg          <= '0;
            poll_active_reg  <= 1'b0;
            s1_valid_reg     <= 1'b0;
            em_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                module_count_reg <= pwdata[fbcd_pkg::COUNT_W-1:0];
            end

            // poll position
            if (in_acc)
            begin
                case (kind)
                    fbcd_pkg::KIND_START:
                    begin
                        pos_reg         <= '0;
                        poll_active_reg <= (reads != '0);
                    end
                    fbcd_pkg::KIND_ERROR:
                    begin
                        poll_active_reg <= 1'b0;
                    end
                    fbcd_pkg::KIND_DATA:
                    begin
                        if (poll_active_reg)
                        begin
                            if (!pos_in_range)
                            begin
                                poll_active_reg <= 1'b0;
                            end
                            else
                            begin
                                pos_reg <= pos_inc;
                                if (RW'(pos_inc) >= reads)
                                begin
                                    poll_active_reg <= 1'b0;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // stage 1 occupancy
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            // emitter occupancy
            if (s1_move)
            begin
                em_valid_reg <= s1_is_cmd_reg || (diff != 8'h00);
            end
            else if (emit && em_last)
            begin
                em_valid_reg <= 1'b0;
            end

            // output register occupancy
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_is_cmd_reg <= (kind == fbcd_pkg::KIND_START);
            s1_cmd_reg    <= cmd_value;
            s1_byte_reg   <= data_byte;
            s1_mod_reg    <= pos_reg[IDX_W-1:0];
        end
        if (s1_move)
        begin
            em_is_cmd_reg <= s1_is_cmd_reg;
            em_cmd_reg    <= s1_cmd_reg;
            em_mask_reg   <= diff;
            em_byte_reg   <= s1_byte_reg;
            em_mod_reg    <= s1_mod_reg;
        end
        else if (emit)
        begin
            em_mask_reg <= rest_mask;
        end
        if (emit)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_reg.result_kind;
    assign command_byte = out_reg.command_byte;
    assign pin_address  = out_reg.pin_address;
    assign occupied     = out_reg.occupied;
    assign last         = out_reg.last;

    // Checks
    `FBCD_ASSERT_IMPLIES(a_stall_needs_item, in_stall, s1_valid_reg, "stall with empty stage 1")
    `FBCD_ASSERT_IMPLIES(a_em_has_work, em_valid_reg, em_is_cmd_reg || (em_mask_reg != 8'h00), "emitter busy with nothing to emit")
    `FBCD_ASSERT_IMPLIES(a_pos_in_store, poll_active_reg, pos_reg < POS_W'(STORE_DEPTH), "poll position past store")
    `FBCD_ASSERT_IMPLIES(a_cmd_is_last, out_valid_reg && (out_reg.result_kind == fbcd_pkg::RES_CMD), out_reg.last, "command beat not marked last")

endmodule
